// ===== rtl/usartft_pkg.sv =====
// Package with the item types, register and flag codes, and the frame length function.
package usartft_pkg;

	// Default width of the frame timers.
	localparam int TIME_WIDTH_DEF = 24;

	// Width of a frame length in clock cycles: 16 * 4096 * 13 fits in 20 bits.
	localparam int FRAME_W = 20;

	// Operation codes.
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_RECV  = 3'd3;
	localparam logic [2:0] OP_TXACK = 3'd4;

	// Register indexes.
	localparam logic [2:0] REG_DATA   = 3'd0;
	localparam logic [2:0] REG_STAT_A = 3'd1;
	localparam logic [2:0] REG_CTRL_B = 3'd2;
	localparam logic [2:0] REG_CTRL_C = 3'd3;
	localparam logic [2:0] REG_BAUD_L = 3'd4;
	localparam logic [2:0] REG_BAUD_H = 3'd5;

	// Status A bit positions.
	localparam int SA_RXC  = 7;
	localparam int SA_TXC  = 6;
	localparam int SA_UDRE = 5;
	localparam int SA_DOR  = 3;
	localparam int SA_U2X  = 1;
	localparam int SA_MPCM = 0;

	// Control B bit positions.
	localparam int CB_RXCIE = 7;
	localparam int CB_TXCIE = 6;
	localparam int CB_UDRIE = 5;
	localparam int CB_RXEN  = 4;
	localparam int CB_TXEN  = 3;
	localparam int CB_SIZE9 = 2;
	localparam int CB_RXB8  = 1;
	localparam int CB_TXB8  = 0;

	// Reset values of the status and control registers.
	localparam logic [7:0] STAT_A_RST = 8'h20;
	localparam logic [7:0] CTRL_C_RST = 8'h06;

	// Interrupt source codes.
	localparam logic [1:0] IRQ_NONE = 2'd0;
	localparam logic [1:0] IRQ_RXC  = 2'd1;
	localparam logic [1:0] IRQ_UDRE = 2'd2;
	localparam logic [1:0] IRQ_TXC  = 2'd3;

	// One command transaction.
	typedef struct packed {
		logic [2:0]  opcode;
		logic [2:0]  reg_index;
		logic [8:0]  data_in;
		logic [15:0] elapsed;
		logic        clock_gated;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0] rd_value;
		logic       tx_valid;
		logic [8:0] tx_frame;
		logic       irq_pending;
		logic [1:0] irq_source;
	} rsp_t;

	// Frame length in clock cycles: bit time times the number of bits in a frame.
	function automatic logic [FRAME_W-1:0] frame_cycles(input logic u2x,
			input logic [11:0] baud, input logic size9, input logic [7:0] ctrl_c);
		logic [16:0] bit_len;
		logic [3:0]  n_data;
		logic [3:0]  frame_bits;
		bit_len = u2x ? (({5'd0, baud} + 17'd1) << 3) : (({5'd0, baud} + 17'd1) << 4);
		n_data = size9 ? 4'd9 : ({2'b00, ctrl_c[2:1]} + 4'd5);
		frame_bits = 4'd1 + n_data + {3'b000, |ctrl_c[5:4]} + (ctrl_c[3] ? 4'd2 : 4'd1);
		return {3'b000, bit_len} * {16'd0, frame_bits};
	endfunction

endpackage

// ===== rtl/usartft_if.sv =====
// Channel interfaces for command and result transactions.
interface usartft_cmd_if;
	logic                 valid;
	logic                 ready;
	usartft_pkg::cmd_t    data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface usartft_rsp_if;
	logic                 valid;
	logic                 ready;
	usartft_pkg::rsp_t    data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/usartft_timer_step.sv =====
// Saturating frame timer advance with end-of-frame compare.
module usartft_timer_step #(
	parameter int TIME_WIDTH = usartft_pkg::TIME_WIDTH_DEF
) (
	input  logic [TIME_WIDTH-1:0]           time_cur,
	input  logic [15:0]                     elapsed,
	input  logic [usartft_pkg::FRAME_W-1:0] limit,
	output logic [TIME_WIDTH-1:0]           time_sum,
	output logic                            done
);

	logic [TIME_WIDTH:0]   sum_wide;
	logic [TIME_WIDTH-1:0] limit_ext;

	// Add the elapsed cycles and clamp at the largest count.
	assign sum_wide = {1'b0, time_cur} + {{(TIME_WIDTH + 1 - 16){1'b0}}, elapsed};
	assign time_sum = sum_wide[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum_wide[TIME_WIDTH-1:0];

	// The frame ends once the count reaches the frame length.
	assign limit_ext = {{(TIME_WIDTH - usartft_pkg::FRAME_W){1'b0}}, limit};
	assign done      = time_sum >= limit_ext;

endmodule

// ===== rtl/usart_register_and_frame_timing.sv =====
// Top level of the USART register block with frame timing.
// The block takes one command transaction per clock cycle unless a stalled result holds it
// back, and returns exactly one result transaction for each: the command lands in an input
// register, and from there the register update, the frame timer advance and the interrupt
// priority are all resolved into the result register. The clock period is set by the frame
// length product (a 17 by 4 bit multiply) feeding the saturating timer add, the end-of-frame
// compare and the leftover subtract. A stalled result holds the input register, so up to two
// transactions are in flight.
module usart_register_and_frame_timing #(
	parameter int TIME_WIDTH = usartft_pkg::TIME_WIDTH_DEF
) (
	input logic             clk,
	input logic             arst_n,
	usartft_cmd_if.sink     cmd,
	usartft_rsp_if.source   rsp
);

	// Input stage and result register.
	logic               cmd_valid_s1;
	usartft_pkg::cmd_t  cmd_s1;
	logic               rsp_valid_q;
	usartft_pkg::rsp_t  rsp_q;
	logic               advance;

	// Architectural state.
	logic [7:0]            receive_data_q, transmit_holding_q, status_a_q;
	logic [7:0]            control_b_q, control_c_q, baud_low_q;
	logic [3:0]            baud_high_q;
	logic                  holding_full_q, tx_busy_q, rx_busy_q;
	logic [8:0]            tx_shift_q;
	logic [TIME_WIDTH-1:0] tx_time_q, rx_time_q;

	// Next state.
	logic [7:0]            receive_data_n, transmit_holding_n, status_a_n;
	logic [7:0]            control_b_n, control_c_n, baud_low_n;
	logic [3:0]            baud_high_n;
	logic                  holding_full_n, tx_busy_n, rx_busy_n;
	logic [8:0]            tx_shift_n;
	logic [TIME_WIDTH-1:0] tx_time_n, rx_time_n;
	usartft_pkg::rsp_t     rsp_n;

	// Frame timing signals.
	logic [usartft_pkg::FRAME_W-1:0] frame_len;
	logic                            tx_start;
	logic [TIME_WIDTH-1:0]           tx_time_base;
	logic [TIME_WIDTH-1:0]           tx_sum, tx_left, rx_sum;
	logic                            tx_done, rx_done;
	logic [8:0]                      load_frame;
	logic                            tick_live;
	logic                            irq_rxc, irq_udre, irq_txc;

	// Handshake: the input stage moves on whenever the result register can take a result.
	assign advance   = cmd_valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !cmd_valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cmd.ready) begin
				cmd_valid_s1 <= cmd.valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
		if (advance) begin
			rsp_q <= rsp_n;
		end
	end

	// Frame length from the current format and baud settings.
	assign frame_len = usartft_pkg::frame_cycles(status_a_q[usartft_pkg::SA_U2X],
		{baud_high_q, baud_low_q}, control_b_q[usartft_pkg::CB_SIZE9], control_c_q);

	// A held byte starts on a tick when the shifter is idle and the transmitter is on.
	assign tick_live  = (cmd_s1.opcode == usartft_pkg::OP_TICK) && !cmd_s1.clock_gated;
	assign tx_start   = !tx_busy_q && holding_full_q && control_b_q[usartft_pkg::CB_TXEN];
	assign tx_time_base = tx_start ? '0 : tx_time_q;
	assign load_frame = {control_b_q[usartft_pkg::CB_TXB8], transmit_holding_q};

	usartft_timer_step #(.TIME_WIDTH(TIME_WIDTH)) u_tx_timer (
		.time_cur  (tx_time_base),
		.elapsed   (cmd_s1.elapsed),
		.limit     (frame_len),
		.time_sum  (tx_sum),
		.done      (tx_done)
	);

	// Time left over after a finished transmit frame.
	assign tx_left = tx_sum - {{(TIME_WIDTH - usartft_pkg::FRAME_W){1'b0}}, frame_len};

	usartft_timer_step #(.TIME_WIDTH(TIME_WIDTH)) u_rx_timer (
		.time_cur  (rx_time_q),
		.elapsed   (cmd_s1.elapsed),
		.limit     (frame_len),
		.time_sum  (rx_sum),
		.done      (rx_done)
	);

	// Register update and result for the transaction in the input stage.
	always_comb begin
		receive_data_n     = receive_data_q;
		transmit_holding_n = transmit_holding_q;
		status_a_n         = status_a_q;
		control_b_n        = control_b_q;
		control_c_n        = control_c_q;
		baud_low_n         = baud_low_q;
		baud_high_n        = baud_high_q;
		holding_full_n     = holding_full_q;
		tx_busy_n          = tx_busy_q;
		rx_busy_n          = rx_busy_q;
		tx_shift_n         = tx_shift_q;
		tx_time_n          = tx_time_q;
		rx_time_n          = rx_time_q;
		rsp_n              = '0;

		case (cmd_s1.opcode)
			usartft_pkg::OP_TICK: begin
				if (tick_live) begin
					// Transmit side: optional start, then advance the running frame.
					if (tx_start) begin
						tx_shift_n     = load_frame;
						tx_busy_n      = 1'b1;
						holding_full_n = 1'b0;
						tx_time_n      = '0;
						status_a_n[usartft_pkg::SA_UDRE] = 1'b1;
						status_a_n[usartft_pkg::SA_TXC]  = 1'b0;
					end
					if (tx_busy_q || tx_start) begin
						tx_time_n = tx_sum;
						if (tx_done) begin
							rsp_n.tx_valid = 1'b1;
							rsp_n.tx_frame = tx_start ? load_frame : tx_shift_q;
							status_a_n[usartft_pkg::SA_TXC] = 1'b1;
							if (holding_full_q && !tx_start) begin
								// Back-to-back reload keeps the leftover time.
								tx_shift_n     = load_frame;
								holding_full_n = 1'b0;
								status_a_n[usartft_pkg::SA_UDRE] = 1'b1;
								status_a_n[usartft_pkg::SA_TXC]  = 1'b0;
								tx_time_n      = tx_left;
							end else begin
								tx_busy_n = 1'b0;
							end
						end
					end
					// Receive side: abandon when disabled, else advance the frame.
					if (!control_b_q[usartft_pkg::CB_RXEN]) begin
						rx_busy_n = 1'b0;
					end else if (rx_busy_q) begin
						rx_time_n = rx_sum;
						if (rx_done) begin
							rx_busy_n = 1'b0;
							status_a_n[usartft_pkg::SA_RXC] = 1'b1;
						end
					end
				end
			end
			usartft_pkg::OP_READ: begin
				case (cmd_s1.reg_index)
					usartft_pkg::REG_DATA: begin
						rsp_n.rd_value = receive_data_q;
						status_a_n[usartft_pkg::SA_RXC] = 1'b0;
						status_a_n[usartft_pkg::SA_DOR] = 1'b0;
					end
					usartft_pkg::REG_STAT_A: rsp_n.rd_value = status_a_q;
					usartft_pkg::REG_CTRL_B: rsp_n.rd_value = control_b_q;
					usartft_pkg::REG_CTRL_C: rsp_n.rd_value = control_c_q;
					usartft_pkg::REG_BAUD_L: rsp_n.rd_value = baud_low_q;
					usartft_pkg::REG_BAUD_H: rsp_n.rd_value = {4'd0, baud_high_q};
					default: rsp_n.rd_value = 8'd0;
				endcase
			end
			usartft_pkg::OP_WRITE: begin
				case (cmd_s1.reg_index)
					usartft_pkg::REG_DATA: begin
						transmit_holding_n = cmd_s1.data_in[7:0];
						holding_full_n     = 1'b1;
						status_a_n[usartft_pkg::SA_UDRE] = 1'b0;
					end
					usartft_pkg::REG_STAT_A: begin
						status_a_n[usartft_pkg::SA_U2X]  = cmd_s1.data_in[usartft_pkg::SA_U2X];
						status_a_n[usartft_pkg::SA_MPCM] = cmd_s1.data_in[usartft_pkg::SA_MPCM];
						// Writing a one to the transmit complete flag clears it.
						if (cmd_s1.data_in[usartft_pkg::SA_TXC]) begin
							status_a_n[usartft_pkg::SA_TXC] = 1'b0;
						end
					end
					usartft_pkg::REG_CTRL_B: control_b_n = cmd_s1.data_in[7:0];
					usartft_pkg::REG_CTRL_C: control_c_n = cmd_s1.data_in[7:0];
					usartft_pkg::REG_BAUD_L: baud_low_n  = cmd_s1.data_in[7:0];
					usartft_pkg::REG_BAUD_H: baud_high_n = cmd_s1.data_in[3:0];
					default: ;
				endcase
			end
			usartft_pkg::OP_RECV: begin
				// A frame arriving while one is pending or unread is an overrun.
				if (control_b_q[usartft_pkg::CB_RXEN]) begin
					if (status_a_q[usartft_pkg::SA_RXC] || rx_busy_q) begin
						status_a_n[usartft_pkg::SA_DOR] = 1'b1;
					end else begin
						receive_data_n = cmd_s1.data_in[7:0];
						control_b_n[usartft_pkg::CB_RXB8] = cmd_s1.data_in[8];
						rx_time_n = '0;
						rx_busy_n = 1'b1;
					end
				end
			end
			usartft_pkg::OP_TXACK: begin
				status_a_n[usartft_pkg::SA_TXC] = 1'b0;
			end
			default: ;
		endcase

		// Prioritized interrupt from the updated flags.
		irq_rxc  = status_a_n[usartft_pkg::SA_RXC] && control_b_n[usartft_pkg::CB_RXCIE];
		irq_udre = status_a_n[usartft_pkg::SA_UDRE] && control_b_n[usartft_pkg::CB_UDRIE];
		irq_txc  = status_a_n[usartft_pkg::SA_TXC] && control_b_n[usartft_pkg::CB_TXCIE];
		if (irq_rxc) begin
			rsp_n.irq_source = usartft_pkg::IRQ_RXC;
		end else if (irq_udre) begin
			rsp_n.irq_source = usartft_pkg::IRQ_UDRE;
		end else if (irq_txc) begin
			rsp_n.irq_source = usartft_pkg::IRQ_TXC;
		end else begin
			rsp_n.irq_source = usartft_pkg::IRQ_NONE;
		end
		rsp_n.irq_pending = irq_rxc || irq_udre || irq_txc;
	end

	// State registers, updated once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receive_data_q     <= 8'd0;
			transmit_holding_q <= 8'd0;
			status_a_q         <= usartft_pkg::STAT_A_RST;
			control_b_q        <= 8'd0;
			control_c_q        <= usartft_pkg::CTRL_C_RST;
			baud_low_q         <= 8'd0;
			baud_high_q        <= 4'd0;
			holding_full_q     <= 1'b0;
			tx_busy_q          <= 1'b0;
			rx_busy_q          <= 1'b0;
			tx_shift_q         <= 9'd0;
			tx_time_q          <= '0;
			rx_time_q          <= '0;
		end else if (advance) begin
			receive_data_q     <= receive_data_n;
			transmit_holding_q <= transmit_holding_n;
			status_a_q         <= status_a_n;
			control_b_q        <= control_b_n;
			control_c_q        <= control_c_n;
			baud_low_q         <= baud_low_n;
			baud_high_q        <= baud_high_n;
			holding_full_q     <= holding_full_n;
			tx_busy_q          <= tx_busy_n;
			rx_busy_q          <= rx_busy_n;
			tx_shift_q         <= tx_shift_n;
			tx_time_q          <= tx_time_n;
			rx_time_q          <= rx_time_n;
		end
	end

endmodule

// ===== rtl/usartft_checker.sv =====
// Port-level checks of the USART register block, bound to the top level.
module usartft_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input usartft_pkg::rsp_t rsp_data
);

	// A stalled result holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// A result only appears after a command transaction was accepted into the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_valid && cmd_ready, 2))
		else $error("result without a command");

	// With no result waiting the block always takes a command.
	assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> cmd_ready)
		else $error("command stalled while the result side is empty");

	// The pending flag and the source code agree, and an idle frame field is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.irq_pending == (rsp_data.irq_source != usartft_pkg::IRQ_NONE))
			&& (rsp_data.tx_valid || rsp_data.tx_frame == 9'd0))
		else $error("inconsistent result fields");

endmodule

bind usart_register_and_frame_timing usartft_checker u_usartft_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
